[rtl/uv_sphere_mesh_generator_assert.svh]
// ----------------------------------------------------------------------------
// UV sphere mesh generator assertion macros
// Shared property wrappers for the checkers of the mesh generator.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_MESH_GENERATOR_ASSERT_SVH
`define UV_SPHERE_MESH_GENERATOR_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define UVSG_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("uv sphere mesh check failed");

// Condition in one cycle requires a consequence in the next cycle.
`define UVSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uv sphere mesh sequencing check failed");

`endif

[rtl/uvsg_pkg.sv]
// ----------------------------------------------------------------------------
// UV sphere mesh generator package
// Payload types, result codes, fixed-point constants and shared arithmetic.
// ----------------------------------------------------------------------------
package uvsg_pkg;

  localparam logic [1:0] KIND_VERTEX   = 2'd0;
  localparam logic [1:0] KIND_TRIANGLE = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  // One divider cell per fractional quotient bit.
  localparam int unsigned NUM_CELLS = 33;
  // Register stages of the sine and cosine unit.
  localparam int unsigned SC_DEPTH  = 11;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [61:0] HALF_Q30 = 62'h2000_0000;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  // Exact reciprocals for quotients of values below 2^30.
  localparam int unsigned SH_72 = 37;
  localparam logic [31:0] RC_72 = 32'(((64'd1 << 37) + 64'd71) / 64'd72);
  localparam int unsigned SH_42 = 36;
  localparam logic [31:0] RC_42 = 32'(((64'd1 << 36) + 64'd41) / 64'd42);
  localparam int unsigned SH_20 = 35;
  localparam logic [31:0] RC_20 = 32'(((64'd1 << 35) + 64'd19) / 64'd20);
  localparam int unsigned SH_6  = 33;
  localparam logic [31:0] RC_6  = 32'(((64'd1 << 33) + 64'd5) / 64'd6);
  localparam int unsigned SH_90 = 37;
  localparam logic [31:0] RC_90 = 32'(((64'd1 << 37) + 64'd89) / 64'd90);
  localparam int unsigned SH_56 = 36;
  localparam logic [31:0] RC_56 = 32'(((64'd1 << 36) + 64'd55) / 64'd56);
  localparam int unsigned SH_30 = 35;
  localparam logic [31:0] RC_30 = 32'(((64'd1 << 35) + 64'd29) / 64'd30);
  localparam int unsigned SH_12 = 34;
  localparam logic [31:0] RC_12 = 32'(((64'd1 << 34) + 64'd11) / 64'd12);

  typedef struct packed {
    logic [7:0] stack_index;
    logic [7:0] sector_index;
  } item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [16:0]        tex_s;
    logic [16:0]        tex_t;
    logic [15:0]        corner_a;
    logic [15:0]        corner_b;
    logic [15:0]        corner_c;
    logic               last;
  } result_t;

  // Divider chain payload: two long divisions by n run side by side.
  typedef struct packed {
    logic        valid;
    logic        err;
    logic [7:0]  i;
    logic [7:0]  j;
    logic [7:0]  n;
    logic [7:0]  ri;
    logic [7:0]  rj;
    logic [33:0] qi;
    logic [33:0] qj;
  } div_t;

  typedef struct packed {
    logic        valid;
    logic        err;
    logic [7:0]  i;
    logic [7:0]  j;
    logic [7:0]  n;
    logic [16:0] tex_s;
    logic [16:0] tex_t;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [31:0] pa;
    logic [31:0] pb;
  } post_t;

  typedef struct packed {
    logic [30:0] sin_mag;
    logic        sin_neg;
    logic [30:0] cos_mag;
    logic        cos_neg;
  } sc_t;

  typedef struct packed {
    logic        valid;
    logic        err;
    logic [7:0]  i;
    logic [7:0]  j;
    logic [7:0]  n;
    logic [16:0] tex_s;
    logic [16:0] tex_t;
    logic [30:0] x_mag;
    logic        x_neg;
    logic [30:0] y_mag;
    logic        y_neg;
    logic [30:0] z_mag;
    logic        z_neg;
    logic [15:0] k1;
  } mid_t;

  // Q2.30 product rounded to nearest.
  function automatic logic [30:0] mulq(input logic [30:0] p, input logic [30:0] q);
    logic [61:0] pr;
    pr = 62'(p) * 62'(q) + HALF_Q30;
    return 31'(pr >> 30);
  endfunction

  // Truncating quotient by a constant through its reciprocal.
  function automatic logic [30:0] div_const(input logic [30:0] v, input logic [31:0] m,
                                            input int unsigned sh);
    logic [62:0] p;
    p = 63'(v) * 63'(m);
    return 31'(p >> sh);
  endfunction

endpackage

[rtl/uv_sphere_mesh_generator.sv]
// Path: divider cells, phase register, sine stages, mid register, then the emitter.
// Throughput: one grid point per cycle while each point yields one result and
// results are taken; a point with triangles holds the output while the emitter
// at the end of the 33-cell divider chain and sine pipeline sends one per cycle.
// Reset is synchronous and active high; it empties the pipeline and sets steps to 24.
// ----------------------------------------------------------------------------
// UV sphere mesh generator
// Turns a stack and sector index into the unit-sphere vertex, its texture
// coordinates and up to two triangles of the row-major vertex grid.
// ----------------------------------------------------------------------------
module uv_sphere_mesh_generator #(
  parameter int MAX_STEPS       = 255,
  parameter int COORD_FRAC_BITS = 14
) (
  input  logic              clk,
  input  logic              rst,
  // Grid point channel.
  input  logic              item_valid,
  output logic              item_ready,
  input  uvsg_pkg::item_t   item,
  // Result channel.
  output logic              result_valid,
  input  logic              result_ready,
  output uvsg_pkg::result_t result,
  // Register port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // The register is 8 bits wide, so a cap above 255 never takes effect.
  localparam int          STEPS_CAP = (MAX_STEPS > 255) ? 255 : MAX_STEPS;
  localparam logic [7:0]  CAP_N     = 8'(STEPS_CAP);

  logic [7:0]            steps;
  logic [7:0]            n_eff;
  logic                  adv;
  logic                  emit_accept;
  logic                  ge_i;
  logic                  ge_j;
  uvsg_pkg::div_t        head;
  uvsg_pkg::div_t        cell_out [uvsg_pkg::NUM_CELLS];
  uvsg_pkg::div_t        tail;
  uvsg_pkg::post_t       post;
  uvsg_pkg::post_t       post_next;
  uvsg_pkg::side_t       line [uvsg_pkg::SC_DEPTH];
  uvsg_pkg::sc_t         sc_a;
  uvsg_pkg::sc_t         sc_b;
  uvsg_pkg::mid_t        mid;
  uvsg_pkg::mid_t        mid_next;
  logic [31:0]           rnd_a;

  // --------------------------------------------------------------------------
  // Register port. Only the word index decodes; other words read as zero and
  // ignore writes. Writes land in the access phase.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, steps} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= 8'd24;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      steps <= pwdata[7:0];
    end
  end

  // Out-of-range step counts act as the nearest legal value.
  assign n_eff = (steps < 8'd2) ? 8'd2 : ((steps > CAP_N) ? CAP_N : steps);

  // --------------------------------------------------------------------------
  // The whole pipeline moves together. It only halts when the last stage holds
  // a point that the emitter cannot take in this cycle; bubbles are not squeezed
  // out, and a new transaction is accepted while results still wait downstream.
  // --------------------------------------------------------------------------
  assign adv        = emit_accept || !mid.valid;
  assign item_ready = adv;

  // --------------------------------------------------------------------------
  // Divider chain. Both indices are divided by n as long divisions: the head
  // settles the integer bit, and each of the 33 cells shifts in one more
  // fraction bit. Rounding to nearest then takes the next quotient bit, since
  // that bit is set exactly when twice the remainder reaches n.
  // --------------------------------------------------------------------------
  always_comb begin
    ge_i       = item.stack_index >= n_eff;
    ge_j       = item.sector_index >= n_eff;
    head.valid = item_valid;
    head.err   = (item.stack_index > n_eff) || (item.sector_index > n_eff);
    head.i     = item.stack_index;
    head.j     = item.sector_index;
    head.n     = n_eff;
    head.ri    = ge_i ? 8'(item.stack_index - n_eff) : item.stack_index;
    head.rj    = ge_j ? 8'(item.sector_index - n_eff) : item.sector_index;
    head.qi    = 34'(ge_i);
    head.qj    = 34'(ge_j);
  end

  for (genvar k = 0; k < uvsg_pkg::NUM_CELLS; k++) begin : g_cell
    if (k == 0) begin : g_first
      uvsg_div_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .en   (adv),
        .din  (head),
        .dout (cell_out[k])
      );
    end else begin : g_next
      uvsg_div_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .en   (adv),
        .din  (cell_out[k-1]),
        .dout (cell_out[k])
      );
    end
  end

  assign tail = cell_out[uvsg_pkg::NUM_CELLS-1];

  // --------------------------------------------------------------------------
  // Phases and texture coordinates. The quotient holds the integer bit at the
  // top and 33 fraction bits below it. The sector phase is j over n in turns,
  // wrapping at a full turn; the stack phase starts a quarter turn up and
  // steps down by half a turn per n stacks.
  // --------------------------------------------------------------------------
  always_comb begin
    rnd_a                = 32'(tail.qi[33:2]) + 32'(tail.qi[1]);
    post_next.side.valid = tail.valid;
    post_next.side.err   = tail.err;
    post_next.side.i     = tail.i;
    post_next.side.j     = tail.j;
    post_next.side.n     = tail.n;
    post_next.side.tex_s = 17'(tail.qj[33:17]) + 17'(tail.qj[16]);
    post_next.side.tex_t = 17'(tail.qi[33:17]) + 17'(tail.qi[16]);
    post_next.pa         = 32'h4000_0000 - rnd_a;
    post_next.pb         = 32'(tail.qj[33:1]) + 32'(tail.qj[0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      post.side.valid <= 1'b0;
    end else if (adv) begin
      post <= post_next;
    end
  end

  // --------------------------------------------------------------------------
  // Sine and cosine of both angles, with the point's side data delayed alongside.
  // --------------------------------------------------------------------------
  uvsg_sincos u_sc_a (
    .clk   (clk),
    .en    (adv),
    .phase (post.pa),
    .sc    (sc_a)
  );

  uvsg_sincos u_sc_b (
    .clk   (clk),
    .en    (adv),
    .phase (post.pb),
    .sc    (sc_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < uvsg_pkg::SC_DEPTH; k++) begin
        line[k].valid <= 1'b0;
      end
    end else if (adv) begin
      line[0] <= post.side;
      for (int k = 1; k < uvsg_pkg::SC_DEPTH; k++) begin
        line[k] <= line[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Position products and the first grid index. x and y scale the ring radius
  // cos(a) by the sector's cosine and sine; z is sin(a) directly.
  // --------------------------------------------------------------------------
  always_comb begin
    mid_next.valid = line[uvsg_pkg::SC_DEPTH-1].valid;
    mid_next.err   = line[uvsg_pkg::SC_DEPTH-1].err;
    mid_next.i     = line[uvsg_pkg::SC_DEPTH-1].i;
    mid_next.j     = line[uvsg_pkg::SC_DEPTH-1].j;
    mid_next.n     = line[uvsg_pkg::SC_DEPTH-1].n;
    mid_next.tex_s = line[uvsg_pkg::SC_DEPTH-1].tex_s;
    mid_next.tex_t = line[uvsg_pkg::SC_DEPTH-1].tex_t;
    mid_next.x_mag = uvsg_pkg::mulq(sc_a.cos_mag, sc_b.cos_mag);
    mid_next.x_neg = sc_a.cos_neg ^ sc_b.cos_neg;
    mid_next.y_mag = uvsg_pkg::mulq(sc_a.cos_mag, sc_b.sin_mag);
    mid_next.y_neg = sc_a.cos_neg ^ sc_b.sin_neg;
    mid_next.z_mag = sc_a.sin_mag;
    mid_next.z_neg = sc_a.sin_neg;
    mid_next.k1    = 16'(17'(line[uvsg_pkg::SC_DEPTH-1].i)
                         * 17'(9'(line[uvsg_pkg::SC_DEPTH-1].n) + 9'd1)
                         + 17'(line[uvsg_pkg::SC_DEPTH-1].j));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid.valid <= 1'b0;
    end else if (adv) begin
      mid <= mid_next;
    end
  end

  // --------------------------------------------------------------------------
  // Emitter: output rounding and saturation, then vertex or error first and
  // the triangles after it, one result transaction per cycle while results are taken.
  // --------------------------------------------------------------------------
  uvsg_emit #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .mid          (mid),
    .accept       (emit_accept),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

[rtl/uvsg_div_cell.sv]
// ----------------------------------------------------------------------------
// UV sphere divider cell
// One restoring division step for the stack and the sector quotient.
// ----------------------------------------------------------------------------
module uvsg_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  uvsg_pkg::div_t din,
  output uvsg_pkg::div_t dout
);

  logic [8:0]     r2i;
  logic [8:0]     r2j;
  logic           gei;
  logic           gej;
  uvsg_pkg::div_t nx;

  always_comb begin
    nx     = din;
    r2i    = {din.ri, 1'b0};
    r2j    = {din.rj, 1'b0};
    gei    = r2i >= {1'b0, din.n};
    gej    = r2j >= {1'b0, din.n};
    nx.ri  = gei ? 8'(r2i - {1'b0, din.n}) : r2i[7:0];
    nx.rj  = gej ? 8'(r2j - {1'b0, din.n}) : r2j[7:0];
    nx.qi  = {din.qi[32:0], gei};
    nx.qj  = {din.qj[32:0], gej};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= nx;
    end
  end

endmodule

[rtl/uvsg_sincos.sv]
// ----------------------------------------------------------------------------
// UV sphere sine and cosine unit
// Pipelined quadrant fold and Horner polynomials on a 2^-32 turn phase.
// ----------------------------------------------------------------------------
module uvsg_sincos (
  input  logic          clk,
  input  logic          en,
  input  logic [31:0]   phase,
  output uvsg_pkg::sc_t sc
);

  typedef struct packed {
    logic [1:0]  quad;
    logic        swap;
    logic [30:0] x;
    logic [30:0] x2;
    logic [30:0] s;
    logic [30:0] c;
  } stage_t;

  stage_t      st [1:uvsg_pkg::SC_DEPTH];
  stage_t      nx [1:uvsg_pkg::SC_DEPTH];
  logic [29:0] r;
  logic [29:0] rf;
  logic [61:0] xp;
  logic [30:0] sv;
  logic [30:0] cv;

  always_comb begin
    for (int k = 2; k <= uvsg_pkg::SC_DEPTH; k++) begin
      nx[k] = st[k-1];
    end
    r  = phase[29:0];
    rf = (r > 30'h2000_0000) ? 30'(31'h4000_0000 - {1'b0, r}) : r;
    xp = 62'(rf) * 62'(uvsg_pkg::PI_Q30);
    nx[1].quad = phase[31:30];
    nx[1].swap = r > 30'h2000_0000;
    nx[1].x    = 31'(xp >> 31);
    nx[1].x2   = '0;
    nx[1].s    = '0;
    nx[1].c    = '0;

    nx[2].x2 = uvsg_pkg::mulq(st[1].x, st[1].x);
    nx[3].s  = uvsg_pkg::div_const(st[2].x2, uvsg_pkg::RC_72, uvsg_pkg::SH_72);
    nx[3].c  = uvsg_pkg::div_const(st[2].x2, uvsg_pkg::RC_90, uvsg_pkg::SH_90);
    nx[4].s  = uvsg_pkg::mulq(st[3].x2, uvsg_pkg::ONE_Q30 - st[3].s);
    nx[4].c  = uvsg_pkg::mulq(st[3].x2, uvsg_pkg::ONE_Q30 - st[3].c);
    nx[5].s  = uvsg_pkg::div_const(st[4].s, uvsg_pkg::RC_42, uvsg_pkg::SH_42);
    nx[5].c  = uvsg_pkg::div_const(st[4].c, uvsg_pkg::RC_56, uvsg_pkg::SH_56);
    nx[6].s  = uvsg_pkg::mulq(st[5].x2, uvsg_pkg::ONE_Q30 - st[5].s);
    nx[6].c  = uvsg_pkg::mulq(st[5].x2, uvsg_pkg::ONE_Q30 - st[5].c);
    nx[7].s  = uvsg_pkg::div_const(st[6].s, uvsg_pkg::RC_20, uvsg_pkg::SH_20);
    nx[7].c  = uvsg_pkg::div_const(st[6].c, uvsg_pkg::RC_30, uvsg_pkg::SH_30);
    nx[8].s  = uvsg_pkg::mulq(st[7].x2, uvsg_pkg::ONE_Q30 - st[7].s);
    nx[8].c  = uvsg_pkg::mulq(st[7].x2, uvsg_pkg::ONE_Q30 - st[7].c);
    nx[9].s  = uvsg_pkg::div_const(st[8].s, uvsg_pkg::RC_6, uvsg_pkg::SH_6);
    nx[9].c  = uvsg_pkg::div_const(st[8].c, uvsg_pkg::RC_12, uvsg_pkg::SH_12);
    // Sine closes with the angle itself, cosine with its last halving term.
    nx[10].s = uvsg_pkg::mulq(st[9].x, uvsg_pkg::ONE_Q30 - st[9].s);
    nx[10].c = uvsg_pkg::mulq(st[9].x2, uvsg_pkg::ONE_Q30 - st[9].c);
    nx[11].c = uvsg_pkg::ONE_Q30 - (st[10].c >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st <= nx;
    end
  end

  always_comb begin
    sv = st[uvsg_pkg::SC_DEPTH].swap ? st[uvsg_pkg::SC_DEPTH].c : st[uvsg_pkg::SC_DEPTH].s;
    cv = st[uvsg_pkg::SC_DEPTH].swap ? st[uvsg_pkg::SC_DEPTH].s : st[uvsg_pkg::SC_DEPTH].c;
    unique case (st[uvsg_pkg::SC_DEPTH].quad)
      2'd0: sc = '{sin_mag: sv, sin_neg: 1'b0, cos_mag: cv, cos_neg: 1'b0};
      2'd1: sc = '{sin_mag: cv, sin_neg: 1'b0, cos_mag: sv, cos_neg: 1'b1};
      2'd2: sc = '{sin_mag: sv, sin_neg: 1'b1, cos_mag: cv, cos_neg: 1'b1};
      default: sc = '{sin_mag: cv, sin_neg: 1'b1, cos_mag: sv, cos_neg: 1'b0};
    endcase
  end

endmodule

[rtl/uvsg_emit.sv]
// ----------------------------------------------------------------------------
// UV sphere result emitter
// Holds one grid point and sends its vertex and triangles one per transaction.
// ----------------------------------------------------------------------------
module uvsg_emit #(
  parameter int COORD_FRAC_BITS = 14
) (
  input  logic              clk,
  input  logic              rst,
  input  uvsg_pkg::mid_t    mid,
  output logic              accept,
  output logic              result_valid,
  input  logic              result_ready,
  output uvsg_pkg::result_t result
);

  localparam int          OUT_SHIFT  = 30 - COORD_FRAC_BITS;
  localparam logic [31:0] ROUND_HALF = (32'd1 << OUT_SHIFT) >> 1;

  logic        vtx_pend;
  logic        a_pend;
  logic        b_pend;
  logic        err_r;
  logic [15:0] px;
  logic [15:0] py;
  logic [15:0] pz;
  logic [16:0] ts;
  logic [16:0] tt;
  logic [15:0] k1;
  logic [15:0] k2;
  logic        has_tri;
  logic        has_a;
  logic        has_b;
  logic        last_now;
  logic        fire;

  function automatic logic [15:0] to_out(input logic [30:0] mag, input logic neg);
    logic [31:0] m;
    m = ({1'b0, mag} + ROUND_HALF) >> OUT_SHIFT;
    if (neg) begin
      if (m > 32'd32768) m = 32'd32768;
      return 16'(32'd0 - m);
    end else begin
      if (m > 32'd32767) m = 32'd32767;
      return m[15:0];
    end
  endfunction

  assign has_tri = !mid.err && (mid.i < mid.n) && (mid.j < mid.n);
  assign has_a   = has_tri && (mid.i != 8'd0);
  assign has_b   = has_tri && (mid.i != 8'(mid.n - 8'd1));

  assign result_valid = vtx_pend | a_pend | b_pend;
  assign fire         = result_valid & result_ready;
  assign accept       = !result_valid | (fire & last_now);

  always_comb begin
    result = '0;
    priority if (vtx_pend) begin
      result.kind  = err_r ? uvsg_pkg::KIND_ERROR : uvsg_pkg::KIND_VERTEX;
      result.pos_x = $signed(px);
      result.pos_y = $signed(py);
      result.pos_z = $signed(pz);
      result.tex_s = ts;
      result.tex_t = tt;
      last_now     = !(a_pend || b_pend);
    end else if (a_pend) begin
      result.kind     = uvsg_pkg::KIND_TRIANGLE;
      result.corner_a = k1;
      result.corner_b = k2;
      result.corner_c = 16'(k1 + 16'd1);
      last_now        = !b_pend;
    end else begin
      result.kind     = uvsg_pkg::KIND_TRIANGLE;
      result.corner_a = 16'(k1 + 16'd1);
      result.corner_b = k2;
      result.corner_c = 16'(k2 + 16'd1);
      last_now        = 1'b1;
    end
    result.last = last_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vtx_pend <= 1'b0;
      a_pend   <= 1'b0;
      b_pend   <= 1'b0;
    end else if (accept) begin
      vtx_pend <= mid.valid;
      a_pend   <= mid.valid & has_a;
      b_pend   <= mid.valid & has_b;
    end else if (fire) begin
      priority if (vtx_pend) begin
        vtx_pend <= 1'b0;
      end else if (a_pend) begin
        a_pend <= 1'b0;
      end else begin
        b_pend <= 1'b0;
      end
    end
  end

  // An error point carries nothing but its kind and last flag.
  always_ff @(posedge clk) begin
    if (accept && mid.valid) begin
      err_r <= mid.err;
      px    <= mid.err ? 16'd0 : to_out(mid.x_mag, mid.x_neg);
      py    <= mid.err ? 16'd0 : to_out(mid.y_mag, mid.y_neg);
      pz    <= mid.err ? 16'd0 : to_out(mid.z_mag, mid.z_neg);
      ts    <= mid.err ? 17'd0 : mid.tex_s;
      tt    <= mid.err ? 17'd0 : mid.tex_t;
      k1    <= mid.k1;
      k2    <= 16'(mid.k1 + 16'(mid.n) + 16'd1);
    end
  end

endmodule

[rtl/uvsg_checker.sv]
// ----------------------------------------------------------------------------
// UV sphere mesh generator checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "uv_sphere_mesh_generator_assert.svh"

module uvsg_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input uvsg_pkg::result_t result
);

  `UVSG_ASSERT_NEXT(a_result_holds, clk, rst, result_valid && !result_ready, result_valid)
  `UVSG_ASSERT(a_error_is_last, clk, rst, (result_valid && result.kind == uvsg_pkg::KIND_ERROR) |-> result.last)
  `UVSG_ASSERT(a_vertex_no_corners, clk, rst, (result_valid && result.kind == uvsg_pkg::KIND_VERTEX) |-> (result.corner_a == 16'd0 && result.corner_b == 16'd0 && result.corner_c == 16'd0 && result.tex_s <= 17'd65536))
  `UVSG_ASSERT(a_tri_follows, clk, rst, (result_valid && $past(!rst && result_valid && result_ready && !result.last)) |-> result.kind == uvsg_pkg::KIND_TRIANGLE)

endmodule

bind uv_sphere_mesh_generator uvsg_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

[bench/uv_sphere_mesh_generator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UV sphere mesh generator testbench
// Streams grid points through the generator under several step counts and
// random stalls on both channels, predicts every vertex, triangle and error
// transaction in fixed point, and checks each result field by field in order.
// ----------------------------------------------------------------------------
module uv_sphere_mesh_generator_tb;

  // The scoreboard keeps the current step count and a queue of the results that
  // the accepted grid points are known to produce, oldest first.
  class mesh_scoreboard;
    uvsg_pkg::result_t pending[$];
    bit [7:0] steps_reg;
    int errors;

    function new();
      steps_reg = 8'd24;
      errors = 0;
    endfunction

    // Rounded quotient floor((2n + d) / (2d)).
    function automatic longint unsigned rdiv(longint unsigned n, longint unsigned d);
      return (2 * n + d) / (2 * d);
    endfunction

    // Q2.30 product rounded to nearest.
    function automatic longint unsigned qmul(longint unsigned p, longint unsigned q);
      return (p * q + 64'h2000_0000) >> 30;
    endfunction

    // Signed sine and cosine of a phase given in 2^-32 turn units.
    function automatic void phase_sincos(bit [31:0] ph, output longint sn,
                                         output longint cs);
      longint unsigned r, x, x2, s, c, sv, cv;
      bit swp;
      r = ph[29:0];
      swp = 0;
      if (r > 64'h2000_0000) begin
        r = 64'h4000_0000 - r;
        swp = 1;
      end
      x = (r * 64'd3373259426) >> 31;
      x2 = qmul(x, x);
      s = 64'h4000_0000 - x2 / 72;
      s = 64'h4000_0000 - qmul(x2, s) / 42;
      s = 64'h4000_0000 - qmul(x2, s) / 20;
      s = 64'h4000_0000 - qmul(x2, s) / 6;
      s = qmul(x, s);
      c = 64'h4000_0000 - x2 / 90;
      c = 64'h4000_0000 - qmul(x2, c) / 56;
      c = 64'h4000_0000 - qmul(x2, c) / 30;
      c = 64'h4000_0000 - qmul(x2, c) / 12;
      c = 64'h4000_0000 - qmul(x2, c) / 2;
      sv = swp ? c : s;
      cv = swp ? s : c;
      case (ph[31:30])
        2'd0: begin sn = sv; cs = cv; end
        2'd1: begin sn = cv; cs = -longint'(sv); end
        2'd2: begin sn = -longint'(sv); cs = -longint'(cv); end
        default: begin sn = -longint'(cv); cs = sv; end
      endcase
    endfunction

    function automatic longint sprod(longint p, longint q);
      longint m;
      m = qmul(p < 0 ? -p : p, q < 0 ? -q : q);
      return ((p < 0) != (q < 0)) ? -m : m;
    endfunction

    // Round Q2.30 half up to the 14-bit fraction and saturate.
    function automatic bit [15:0] to_coord(longint v);
      longint unsigned m;
      m = ((v < 0 ? -v : v) + (1 << 15)) >> 16;
      if (v < 0) begin
        if (m > 32768) m = 32768;
        return 16'(-longint'(m));
      end
      if (m > 32767) m = 32767;
      return 16'(m);
    endfunction

    function automatic uvsg_pkg::result_t make_tri(longint unsigned a, longint unsigned b,
                                                   longint unsigned c);
      uvsg_pkg::result_t t;
      t = '0;
      t.kind = uvsg_pkg::KIND_TRIANGLE;
      t.corner_a = a[15:0];
      t.corner_b = b[15:0];
      t.corner_c = c[15:0];
      return t;
    endfunction

    // Note an accepted grid point and queue the results it must give.
    function void note_point(uvsg_pkg::item_t it);
      longint unsigned n, i, j, k1, k2;
      bit [31:0] pa, pb;
      longint sa, ca, sb, cb;
      uvsg_pkg::result_t v;
      uvsg_pkg::result_t outs[$];
      n = steps_reg;
      if (n < 2) n = 2;
      i = it.stack_index;
      j = it.sector_index;
      v = '0;
      if (i > n || j > n) begin
        v.kind = uvsg_pkg::KIND_ERROR;
        v.last = 1'b1;
        pending.push_back(v);
        return;
      end
      pb = 32'(rdiv(j << 32, n));
      pa = 32'(64'h4000_0000 - rdiv(i << 31, n));
      phase_sincos(pa, sa, ca);
      phase_sincos(pb, sb, cb);
      v.kind = uvsg_pkg::KIND_VERTEX;
      v.pos_x = to_coord(sprod(ca, cb));
      v.pos_y = to_coord(sprod(ca, sb));
      v.pos_z = to_coord(sa);
      v.tex_s = 17'(rdiv(j << 16, n));
      v.tex_t = 17'(rdiv(i << 16, n));
      outs.push_back(v);
      if (i < n && j < n) begin
        k1 = i * (n + 1) + j;
        k2 = k1 + n + 1;
        if (i != 0) outs.push_back(make_tri(k1, k2, k1 + 1));
        if (i != n - 1) outs.push_back(make_tri(k1 + 1, k2, k2 + 1));
      end
      outs[outs.size() - 1].last = 1'b1;
      foreach (outs[k]) pending.push_back(outs[k]);
    endfunction

    // Compare one result transaction with the oldest expectation.
    function void check_result(uvsg_pkg::result_t got);
      uvsg_pkg::result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.kind != exp_r.kind) report("kind", exp_r.kind, got.kind);
      if (got.pos_x != exp_r.pos_x) report("pos_x", exp_r.pos_x, got.pos_x);
      if (got.pos_y != exp_r.pos_y) report("pos_y", exp_r.pos_y, got.pos_y);
      if (got.pos_z != exp_r.pos_z) report("pos_z", exp_r.pos_z, got.pos_z);
      if (got.tex_s != exp_r.tex_s) report("tex_s", exp_r.tex_s, got.tex_s);
      if (got.tex_t != exp_r.tex_t) report("tex_t", exp_r.tex_t, got.tex_t);
      if (got.corner_a != exp_r.corner_a) report("corner_a", exp_r.corner_a, got.corner_a);
      if (got.corner_b != exp_r.corner_b) report("corner_b", exp_r.corner_b, got.corner_b);
      if (got.corner_c != exp_r.corner_c) report("corner_c", exp_r.corner_c, got.corner_c);
      if (got.last != exp_r.last) report("last", exp_r.last, got.last);
    endfunction

    function void report(string fld, longint unsigned e, longint unsigned a);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fld, e, a);
      errors++;
    endfunction
  endclass

  localparam int STEPS_ADDR = 0;  // byte address of the steps register

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  uvsg_pkg::item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  uvsg_pkg::result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  mesh_scoreboard board = new();

  // Idling rates in percent; the receiver can also be held off completely.
  int send_idle = 0;
  int recv_idle = 0;
  bit recv_hold = 0;

  always #4 clk = ~clk;

  uv_sphere_mesh_generator DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Result side: check every accepted transaction, then choose the next ready.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) board.check_result(result);
      result_ready <= !recv_hold && ($urandom_range(99) >= recv_idle);
    end
  end

  // Offer one grid point and hold it until the block takes it.
  task automatic send_point(input bit [7:0] i, input bit [7:0] j);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{stack_index: i, sector_index: j};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    board.note_point('{stack_index: i, sector_index: j});
  endtask

  // Wait until every expected result has arrived, then let the pipe drain.
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Register write in a setup and an access cycle, only while the block is idle.
  task automatic write_steps(input bit [7:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'(STEPS_ADDR);
    pwdata <= {8'($urandom_range(255)), 16'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.steps_reg = val;
    @(posedge clk);
  endtask

  // One random grid point: mostly on the grid, some beyond it.
  task automatic random_point();
    int n;
    n = board.steps_reg < 2 ? 2 : board.steps_reg;
    if ($urandom_range(9) == 0)
      send_point(8'($urandom_range(255)), 8'($urandom_range(255)));
    else
      send_point(8'($urandom_range(n)), 8'($urandom_range(n)));
  endtask

  initial begin
    int n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed points at the reset step count of 24: poles, seam, the rows
    // next to the poles that lose one triangle, and points beyond the grid.
    send_point(0, 0);
    send_point(0, 5);
    send_point(1, 3);
    send_point(12, 6);
    send_point(23, 23);
    send_point(23, 0);
    send_point(24, 7);
    send_point(5, 24);
    send_point(24, 24);
    send_point(25, 0);
    send_point(0, 25);
    send_point(255, 255);
    send_point(8'hAA, 8'h55);
    send_point(8'h55, 8'hAA);
    drain();

    // Step counts below the minimum act as two.
    write_steps(0);
    send_point(0, 0);
    send_point(1, 1);
    send_point(2, 2);
    send_point(3, 0);
    drain();
    write_steps(1);
    send_point(1, 0);
    send_point(0, 1);
    drain();

    // Largest step count: the last grid corners reach the top of 16 bits.
    write_steps(255);
    send_point(254, 254);
    send_point(255, 255);
    send_point(128, 64);
    send_point(0, 254);
    drain();

    // Random phases over several step counts and idling schemes.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_steps(2); send_idle = 19; recv_idle = 70; end
        1: begin write_steps(7); send_idle = 70; recv_idle = 19; end
        2: begin write_steps(8'($urandom_range(3, 254))); send_idle = 0; recv_idle = 0; end
        3: begin write_steps(24); send_idle = 19; recv_idle = 70; end
        default: begin write_steps(255); send_idle = 0; recv_idle = 0; end
      endcase
      for (int k = 0; k < 44; k++) random_point();
      drain();
    end

    // Back pressure: hold the receiver off for a long stretch while points
    // keep coming, more than the pipeline holds, so the input stalls.
    fork
      begin
        recv_hold = 1;
        repeat (300) @(posedge clk);
        recv_hold = 0;
      end
      for (int k = 0; k < 80; k++) random_point();
    join
    drain();

    if (board.errors == 0) $display("** uv_sphere_mesh_generator: PASSED **");
    else $display("** uv_sphere_mesh_generator: FAILED **");
    $finish;
  end

  initial begin
    #(4_000_000);
    $display("** uv_sphere_mesh_generator: FAILED **");
    $finish;
  end
endmodule
